>>> hw/rtl/sli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list block.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

>>> hw/rtl/sli_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_in_if
// Command channel: operation and value with valid/ready.
// ----------------------------------------------------------------------------
interface sli_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

>>> hw/rtl/sli_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_out_if
// Result channel: status, dumped entry, last flag and entry count.
// ----------------------------------------------------------------------------
interface sli_out_if #(
  parameter int unsigned CntW = 5
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] item_value;
  logic               last;
  logic [CntW-1:0]    entry_count;

  modport source (output valid, output status, output item_value, output last,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input item_value, input last,
                  input entry_count, output ready);
endinterface

>>> hw/rtl/sli_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sli_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [IdxW-1:0]        waddr_i,
  input  logic signed [31:0]     wdata_i,
  input  logic                   re_i,
  input  logic [IdxW-1:0]        raddr_i,
  output logic signed [31:0]     rdata_o
);

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer: scans and shifts the store for insert/remove, streams dumps,
// and holds the result register.
// ----------------------------------------------------------------------------
module sli_ctrl #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned CntW     = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sli_in_if.sink             in_i,
  sli_out_if.source          out_o,
  output logic               we_o,
  output logic [IdxW-1:0]    waddr_o,
  output logic signed [31:0] wdata_o,
  output logic               re_o,
  output logic [IdxW-1:0]    raddr_o,
  input  logic signed [31:0] rdata_i
);
  import sli_pkg::*;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_LAST,
    S_REM_RD,
    S_REM_CMP,
    S_DMP_RD,
    S_DMP_CMP,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [IdxW-1:0]    idx_q;
  logic [CntW-1:0]    count_q;
  logic signed [31:0] value_q;
  logic               found_q;
  status_e            status_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic signed [31:0] out_item_q;
  logic               out_last_q;
  logic [CntW-1:0]    out_count_q;

  logic            slot_free;
  logic            out_load;
  logic [IdxW-1:0] top_idx;

  assign slot_free = !out_valid_q || out_o.ready;
  assign out_load  = (state_q == S_DMP_CMP) || ((state_q == S_RESP) && slot_free);
  assign top_idx   = IdxW'(count_q - 1'b1);
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.item_value  = out_item_q;
  assign out_o.last        = out_last_q;
  assign out_o.entry_count = out_count_q;

  // store access
  always_comb begin
    we_o    = 1'b0;
    waddr_o = idx_q + 1'b1;
    wdata_o = value_q;
    re_o    = 1'b0;
    raddr_o = idx_q;
    unique case (state_q)
      S_INS_RD, S_REM_RD: re_o = 1'b1;
      S_DMP_RD:           re_o = slot_free;
      S_INS_CMP: begin
        we_o = 1'b1;
        if (rdata_i > value_q) begin
          wdata_o = rdata_i;
        end
      end
      S_INS_LAST: begin
        we_o    = 1'b1;
        waddr_o = '0;
      end
      S_REM_CMP: begin
        we_o    = found_q;
        waddr_o = idx_q - 1'b1;
        wdata_o = rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      count_q      <= '0;
      value_q      <= '0;
      found_q      <= 1'b0;
      status_q     <= ST_OK;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_item_q   <= '0;
      out_last_q   <= 1'b0;
      out_count_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            value_q  <= in_i.value;
            found_q  <= 1'b0;
            status_q <= ST_OK;
            unique case (in_i.operation)
              OP_INSERT: begin
                if (count_q == CapCnt) begin
                  status_q <= ST_FULL;
                  state_q  <= S_RESP;
                end else if (count_q == '0) begin
                  state_q <= S_INS_LAST;
                end else begin
                  idx_q   <= top_idx;
                  state_q <= S_INS_RD;
                end
              end
              OP_REMOVE: begin
                idx_q <= '0;
                if (count_q == '0) begin
                  status_q <= ST_NOT_FOUND;
                  state_q  <= S_RESP;
                end else begin
                  state_q <= S_REM_RD;
                end
              end
              OP_DUMP: begin
                idx_q <= top_idx;
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_RESP;
                end else begin
                  state_q <= S_DMP_RD;
                end
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_INS_RD: state_q <= S_INS_CMP;
        S_INS_CMP: begin
          if (rdata_i > value_q) begin
            if (idx_q == '0) begin
              state_q <= S_INS_LAST;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_INS_RD;
            end
          end else begin
            count_q <= count_q + 1'b1;
            state_q <= S_RESP;
          end
        end
        S_INS_LAST: begin
          count_q <= count_q + 1'b1;
          state_q <= S_RESP;
        end
        S_REM_RD: state_q <= S_REM_CMP;
        S_REM_CMP: begin
          if (!found_q && rdata_i == value_q) begin
            found_q <= 1'b1;
          end
          if (idx_q == top_idx) begin
            if (found_q || rdata_i == value_q) begin
              count_q <= count_q - 1'b1;
            end else begin
              status_q <= ST_NOT_FOUND;
            end
            state_q <= S_RESP;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_REM_RD;
          end
        end
        S_DMP_RD: begin
          if (slot_free) begin
            state_q <= S_DMP_CMP;
          end
        end
        S_DMP_CMP: begin
          out_status_q <= ST_OK;
          out_item_q   <= rdata_i;
          out_last_q   <= (idx_q == '0);
          out_count_q  <= count_q;
          if (idx_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_DMP_RD;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_status_q <= status_q;
            out_item_q   <= '0;
            out_last_q   <= 1'b1;
            out_count_q  <= count_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/sorted_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// Bounded ascending list of signed 32-bit values held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Commands arrive on in_i (operation, value) and results leave on out_o
// (status, item_value, last, entry_count), both valid/ready.
// Insert walks down from the top entry, shifting larger entries up one place
// until the slot is found. Remove walks up the whole list, compacting behind
// the match. Insert into a full list, remove from an empty one, dump of an
// empty list and code 3 answer without touching the store.
// Dump streams the entries largest first, reading each one before it is sent.
// Each step waits on the registered read of the single RAM port pair.
// One command is worked at a time; in_i.ready is high only between commands.
// A stall on out_o holds the result register and pauses the dump.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_in_if.sink    in_i,
  sli_out_if.source out_o
);
  import sli_pkg::*;

  logic               we;
  logic [IdxW-1:0]    waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [IdxW-1:0]    raddr;
  logic signed [31:0] rdata;

  sli_ctrl #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  sli_mem #(
    .Depth (CAPACITY),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

>>> verif/sorted_list_insert_remove_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_tb
// Self-checking bench for the bounded sorted list.
// ----------------------------------------------------------------------------
// Commands go in through the command interface. Each accepted command updates
// a local ascending copy of the list, and that copy predicts the status, the
// dumped entry, the last flag and the entry count of every result. Results
// are checked in order as each transfer completes. The stimulus covers empty
// and full lists, value extremes, duplicates, misses, the spare opcode and
// long random runs. Both sides idle at random, the result side is held off
// for a long stretch, and the command side pauses until all results are in.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_tb;
  import sli_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned IdlePct    = 27;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 60;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] item;
    logic                     last;
    logic [CntW-1:0]          count;
  } list_result_t;

  logic clk;
  logic rst_n;

  sli_in_if                   cmd_if ();
  sli_out_if #(.CntW(CntW))   res_if ();

  sorted_list_insert_remove #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  logic signed [ValueW-1:0] sorted_vals[$];
  list_result_t             expected_results[$];
  int unsigned              mismatch_count = 0;
  bit                       no_idle = 1'b0;
  int unsigned              hold_req_id = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Ascending copy of the list; computes every result of one command
  function automatic void predict_list_op(input logic [OpW-1:0] op,
                                          input logic signed [ValueW-1:0] val);
    int pos;
    int found;
    pos   = sorted_vals.size();
    found = -1;
    if (op == OP_INSERT) begin
      if (sorted_vals.size() >= Capacity) begin
        expected_results.push_back({ST_FULL, 32'sd0, 1'b1, CntW'(sorted_vals.size())});
      end else begin
        for (int i = sorted_vals.size() - 1; i >= 0; i--) begin
          if (sorted_vals[i] > val) pos = i;
        end
        sorted_vals.insert(pos, val);
        expected_results.push_back({ST_OK, 32'sd0, 1'b1, CntW'(sorted_vals.size())});
      end
    end else if (op == OP_REMOVE) begin
      for (int i = sorted_vals.size() - 1; i >= 0; i--) begin
        if (sorted_vals[i] == val) found = i;
      end
      if (found >= 0) begin
        sorted_vals.delete(found);
        expected_results.push_back({ST_OK, 32'sd0, 1'b1, CntW'(sorted_vals.size())});
      end else begin
        expected_results.push_back({ST_NOT_FOUND, 32'sd0, 1'b1,
                                    CntW'(sorted_vals.size())});
      end
    end else if (op == OP_DUMP) begin
      if (sorted_vals.size() == 0) begin
        expected_results.push_back({ST_EMPTY, 32'sd0, 1'b1, CntW'(0)});
      end else begin
        for (int i = sorted_vals.size() - 1; i >= 0; i--) begin
          expected_results.push_back({ST_OK, sorted_vals[i], (i == 0),
                                      CntW'(sorted_vals.size())});
        end
      end
    end else begin
      expected_results.push_back({ST_OK, 32'sd0, 1'b1, CntW'(sorted_vals.size())});
    end
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return int'($urandom_range(16)) - 8;
    if (sel < 52) begin
      case ($urandom_range(5))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return 32'sh7fff_fffe;
        3:       return 32'sh8000_0001;
        4:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic signed [ValueW-1:0] pick_remove_value();
    if (sorted_vals.size() != 0 && $urandom_range(99) < 65)
      return sorted_vals[$urandom_range(sorted_vals.size() - 1)];
    return pick_value();
  endfunction

  // One command transfer; valid stays high across back-to-back commands
  task automatic send_cmd(input logic [OpW-1:0] op, input logic signed [ValueW-1:0] val);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.value     <= val;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_list_op(op, val);
  endtask

  task automatic send_random(input bit grow);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)                     send_cmd(OpUnused, $urandom());
    else if (r < 20)               send_cmd(OP_DUMP, $urandom());
    else if (r < (grow ? 75 : 40)) send_cmd(OP_INSERT, pick_value());
    else                           send_cmd(OP_REMOVE, pick_remove_value());
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_cmd(OP_DUMP, 32'sd0);
    send_cmd(OP_REMOVE, 32'sd7);
    send_cmd(OpUnused, 32'sh7fff_ffff);
    wait_drained();
  endtask

  task automatic test_edge_values();
    send_cmd(OP_INSERT, 32'sh7fff_ffff);
    send_cmd(OP_INSERT, 32'sh8000_0000);
    send_cmd(OP_INSERT, 32'sd0);
    send_cmd(OP_INSERT, -32'sd1);
    send_cmd(OP_INSERT, 32'sd5);
    send_cmd(OP_INSERT, 32'sd5);
    send_cmd(OP_INSERT, 32'sd1);
    send_cmd(OP_REMOVE, 32'sd9);
    send_cmd(OP_REMOVE, 32'sd5);
    send_cmd(OP_DUMP, -32'sd1);
    send_cmd(OP_REMOVE, 32'sh8000_0000);
    send_cmd(OP_REMOVE, 32'sh7fff_ffff);
    send_cmd(OpUnused, -32'sd1);
    send_cmd(OP_DUMP, 32'sd0);
    wait_drained();
  endtask

  task automatic test_full_list();
    while (sorted_vals.size() < Capacity) send_cmd(OP_INSERT, pick_value());
    send_cmd(OP_INSERT, 32'sh8000_0000);
    send_cmd(OP_INSERT, pick_value());
    send_cmd(OP_DUMP, 32'sd0);
    send_cmd(OP_REMOVE, 32'sd123457);
    while (sorted_vals.size() != 0)
      send_cmd(OP_REMOVE, sorted_vals[$urandom_range(sorted_vals.size() - 1)]);
    send_cmd(OP_DUMP, 32'sd0);
    wait_drained();
  endtask

  // Result side held off while commands keep coming, so the block stalls
  task automatic test_backpressure();
    hold_req_id <= hold_req_id + 1;
    for (int i = 0; i < 30; i++) send_random(1'b1);
    wait_drained();
  endtask

  task automatic test_quiet_stretch();
    no_idle = 1'b1;
    for (int i = 0; i < 60; i++) send_random(i < 30);
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_random(((i / 40) % 2) == 0);
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned seen_id;
    hold_left    = 0;
    seen_id      = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_id != seen_id) begin
        seen_id   = hold_req_id;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d value %0d",
                 $time, res_if.status, res_if.item_value);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_if.status !== want.status) begin
          $display("%0t: status: expected %0d, got %0d", $time, want.status, res_if.status);
          mismatch_count++;
        end
        if (res_if.item_value !== want.item) begin
          $display("%0t: item_value: expected %0d, got %0d",
                   $time, want.item, res_if.item_value);
          mismatch_count++;
        end
        if (res_if.last !== want.last) begin
          $display("%0t: last: expected %0d, got %0d", $time, want.last, res_if.last);
          mismatch_count++;
        end
        if (res_if.entry_count !== want.count) begin
          $display("%0t: entry_count: expected %0d, got %0d",
                   $time, want.count, res_if.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_INSERT;
    cmd_if.value     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_backpressure();
    test_quiet_stretch();
    test_random_mix(160);

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
